// File: hdl/orwm_pkg.sv
// Shared widths, reset values, divider operation codes and control structs.
package orwm_pkg;

   // Fixed field widths.
   localparam int DATA_W    = 16;
   localparam int TOL_W     = 7;
   localparam int FS_W      = 16;
   localparam int KEPT_W    = 7;

   // Shared divider: 23-bit dividend covers every quotient the block forms.
   localparam int DIV_W     = 23;
   localparam int DEN_W     = 16;

   // Default window length and percent scale.
   localparam int WINDOW_LEN_DEFAULT = 10;
   localparam int PCT = 100;

   // Register reset values.
   localparam logic [TOL_W-1:0] TOL_RESET = 7'd10;
   localparam logic [FS_W-1:0]  FS_RESET  = 16'd3000;

   // Divider operation codes.
   localparam logic [1:0] DIV_MEAN = 2'd0;
   localparam logic [1:0] DIV_DEV  = 2'd1;
   localparam logic [1:0] DIV_FILT = 2'd2;
   localparam logic [1:0] DIV_DUTY = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       store;
      logic       scan_start;
      logic       keep_pass;
      logic       div_start;
      logic [1:0] div_op;
      logic       band_load;
      logic       load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic kept_zero;
      logic fs_zero;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/outlier_rejecting_window_mean.sv
// Top level of the outlier-rejecting window mean: register port, controller and datapath.
//
//   Requests carry one millivolt sample on req_sample_mv and are taken when
//   req_valid is high and req_stall is low. Each request writes the oldest
//   window entry and yields exactly one response: filtered mean, kept count
//   and duty percent, held on rsp_* while rsp_valid is high and rsp_stall
//   is high, and taken when rsp_stall is low.
//   The block works on one request at a time. Between acceptance and
//   response it makes two passes over the window memory at one entry per
//   cycle, two reciprocal multiplications for the divisions by the window
//   length and by one hundred, and two runs of the 23-step divider. An
//   empty band skips both runs, a zero full scale the second one. The next
//   request is taken in the cycle after the response is loaded, even while
//   it waits for the consumer; a stalled consumer holds the block only
//   when the following result is ready.
//   Reset empties the window (entries read as zero until written), rewinds
//   the write position, drops any pending response and restores tolerance
//   10 percent and full scale 3000 mV. Registers: tolerance_percent at
//   byte address 0, full_scale_mv at 4; write them only while idle.
module outlier_rejecting_window_mean
   import orwm_pkg::*;
#(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_sample_mv,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_filtered_mean,
   output logic [KEPT_W-1:0] rsp_kept_count,
   output logic [DATA_W-1:0] rsp_duty_percent,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam logic REG_TOL = 1'b0;
   localparam logic REG_FS  = 1'b1;

   logic [TOL_W-1:0] tol_ff;
   logic [FS_W-1:0]  fs_ff;
   logic             csr_write;
   cmd_type          cmd;
   stat_type         stat;

   // Register writes complete on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         fs_ff  <= FS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TOL: tol_ff <= csr_pwdata[TOL_W-1:0];
            REG_FS:  fs_ff  <= csr_pwdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      unique case (csr_paddr[2])
         REG_TOL: csr_prdata = 32'(tol_ff);
         REG_FS:  csr_prdata = 32'(fs_ff);
         default: csr_prdata = '0;
      endcase
   end

   orwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   orwm_datapath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .sample_mv         (req_sample_mv),
      .tolerance_percent (tol_ff),
      .full_scale_mv     (fs_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_filtered_mean (rsp_filtered_mean),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_duty_percent  (rsp_duty_percent)
   );

endmodule

// File: hdl/orwm_div.sv
// Restoring divider, one quotient bit per cycle.
module orwm_div
   import orwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic             take;
   logic [DEN_W:0]   diff;

   // Shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      take  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/orwm_datapath.sv
// Window memory, scan accumulators, band registers, shared divider and result register.
module orwm_datapath
   import orwm_pkg::*;
#(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [DATA_W-1:0] sample_mv,
   input  logic [TOL_W-1:0]  tolerance_percent,
   input  logic [FS_W-1:0]   full_scale_mv,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_filtered_mean,
   output logic [KEPT_W-1:0] rsp_kept_count,
   output logic [DATA_W-1:0] rsp_duty_percent
);

   localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

   // Reciprocal constants for the divisions by the window length and by one hundred.
   // The shift is the dividend width plus the divisor's bit length, which keeps the
   // rounded-up reciprocal exact for every dividend the block forms.
   localparam int RCP_W      = 24;
   localparam int PROD_W     = DIV_W + RCP_W;
   localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int DEV_SHIFT  = DIV_W + $clog2(PCT);
   localparam logic [RCP_W-1:0] MEAN_RCP =
      RCP_W'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
   localparam logic [RCP_W-1:0] DEV_RCP =
      RCP_W'(((64'd1 << DEV_SHIFT) + 64'(PCT) - 64'd1) / 64'(PCT));

   // Window storage with one valid bit per entry; an unwritten entry reads as zero.
   logic [DATA_W-1:0]     mem_ff [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [IDX_W-1:0]      wr_pos_ff;
   logic [IDX_W-1:0]      wr_pos_in;

   // Scan engine.
   logic [IDX_W-1:0]  scan_addr_ff;
   logic              issue_ff;
   logic              rd_vld_ff;
   logic              rd_last_ff;
   logic              rd_hit_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              pass_ff;

   // Accumulators and intermediate results.
   logic [SUM_W-1:0]  total_ff;
   logic [SUM_W-1:0]  kept_sum_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic [DATA_W-1:0] mean_ff;
   logic [DATA_W:0]   dev_ff;
   logic              lo_neg_ff;
   logic [DATA_W:0]   lo_ff;
   logic [DATA_W+1:0] hi_ff;
   logic [DATA_W-1:0] filt_ff;
   logic [DATA_W-1:0] duty_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_mean_ff;
   logic [KEPT_W-1:0] rsp_kept_ff;
   logic [DATA_W-1:0] rsp_duty_ff;

   // Divider hookup.
   logic [1:0]        div_op_ff;
   logic [DIV_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_go;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;

   // Reciprocal multiplier for the constant divisions.
   logic              cst_go;
   logic              cst_busy_ff;
   logic              cst_done_ff;
   logic [DIV_W-1:0]  cst_num_ff;
   logic [RCP_W-1:0]  cst_rcp;
   logic [PROD_W-1:0] cst_prod_ff;

   logic [DATA_W-1:0] samp_val;
   logic              in_band;

   // Next write position wraps after the last entry.
   assign wr_pos_in = (wr_pos_ff == LAST_IDX) ? '0 : wr_pos_ff + 1'b1;

   // Memory write on request and registered read during a scan.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem_ff[wr_pos_ff] <= sample_mv;
      end
      if (issue_ff) begin
         rd_data_ff <= mem_ff[scan_addr_ff];
      end
   end

   // Valid bits, write pointer and scan sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         wr_pos_ff    <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         scan_addr_ff <= '0;
      end else begin
         if (cmd.store) begin
            valid_ff[wr_pos_ff] <= 1'b1;
            wr_pos_ff           <= wr_pos_in;
         end
         rd_vld_ff  <= issue_ff;
         rd_last_ff <= issue_ff && (scan_addr_ff == LAST_IDX);
         if (cmd.scan_start) begin
            issue_ff     <= 1'b1;
            scan_addr_ff <= '0;
         end else if (issue_ff) begin
            if (scan_addr_ff == LAST_IDX) begin
               issue_ff <= 1'b0;
            end
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue_ff) begin
         rd_hit_ff <= valid_ff[scan_addr_ff];
      end
   end

   // Band test on the entry coming out of the memory.
   always_comb begin
      samp_val = rd_hit_ff ? rd_data_ff : '0;
      in_band  = (lo_neg_ff || ({1'b0, samp_val} >= lo_ff)) &&
                 ({2'b00, samp_val} <= hi_ff);
   end

   // Window sum on the first pass, kept sum and count on the second.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         pass_ff     <= cmd.keep_pass;
         total_ff    <= '0;
         kept_sum_ff <= '0;
         kept_ff     <= '0;
      end else if (rd_vld_ff) begin
         if (!pass_ff) begin
            total_ff <= total_ff + SUM_W'(samp_val);
         end else if (in_band) begin
            kept_sum_ff <= kept_sum_ff + SUM_W'(samp_val);
            kept_ff     <= kept_ff + 1'b1;
         end
      end
   end

   // Operands for each operation; the constant divisions leave the divider idle.
   always_comb begin
      case (cmd.div_op)
         DIV_MEAN: begin
            div_num = DIV_W'(total_ff);
            div_den = '0;
         end
         DIV_DEV: begin
            div_num = DIV_W'(mean_ff) * DIV_W'(tolerance_percent);
            div_den = '0;
         end
         DIV_FILT: begin
            div_num = DIV_W'(kept_sum_ff);
            div_den = DEN_W'(kept_ff);
         end
         default: begin
            div_num = DIV_W'(filt_ff) * DIV_W'(PCT);
            div_den = full_scale_mv;
         end
      endcase
   end

   // Divisions by constants go to the reciprocal multiplier, the others to the divider.
   assign cst_go  = cmd.div_start && ((cmd.div_op == DIV_MEAN) || (cmd.div_op == DIV_DEV));
   assign div_go  = cmd.div_start && !cst_go;
   assign cst_rcp = (div_op_ff == DIV_MEAN) ? MEAN_RCP : DEV_RCP;

   // Operand register, then product register; the quotient is a bit field of the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         cst_busy_ff <= 1'b0;
         cst_done_ff <= 1'b0;
      end else begin
         cst_busy_ff <= cst_go;
         cst_done_ff <= cst_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cst_go) begin
         cst_num_ff <= div_num;
      end
      if (cst_busy_ff) begin
         cst_prod_ff <= PROD_W'(cst_num_ff) * PROD_W'(cst_rcp);
      end
   end

   orwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Capture each quotient; filtered mean and duty start from zero each request.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_op_ff <= cmd.div_op;
      end
      if (cmd.scan_start && !cmd.keep_pass) begin
         filt_ff <= '0;
         duty_ff <= '0;
      end else if (div_done || cst_done_ff) begin
         case (div_op_ff)
            DIV_MEAN: mean_ff <= cst_prod_ff[MEAN_SHIFT +: DATA_W];
            DIV_DEV:  dev_ff  <= cst_prod_ff[DEV_SHIFT +: DATA_W+1];
            DIV_FILT: filt_ff <= div_quo[DATA_W-1:0];
            default:  duty_ff <= (|div_quo[DIV_W-1:DATA_W]) ? '1 : div_quo[DATA_W-1:0];
         endcase
      end
   end

   // Band edges; the lower edge flags when it drops below zero.
   always_ff @(posedge clock) begin
      if (cmd.band_load) begin
         lo_neg_ff <= dev_ff > {1'b0, mean_ff};
         lo_ff     <= {1'b0, mean_ff} - dev_ff;
         hi_ff     <= {2'b00, mean_ff} + {1'b0, dev_ff};
      end
   end

   // Result register toward the consumer.
   assign rsp_valid_in = cmd.load_out ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_mean_ff <= filt_ff;
         rsp_kept_ff <= KEPT_W'(kept_ff);
         rsp_duty_ff <= duty_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_mean = rsp_mean_ff;
   assign rsp_kept_count    = rsp_kept_ff;
   assign rsp_duty_percent  = rsp_duty_ff;

   // Status toward the controller.
   always_comb begin
      stat.scan_done = rd_vld_ff && rd_last_ff;
      stat.div_done  = div_done || cst_done_ff;
      stat.kept_zero = (kept_ff == '0);
      stat.fs_zero   = (full_scale_mv == '0);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// File: hdl/orwm_ctrl.sv
// Sequencer that steps one request through the scans, divisions and result load.
module orwm_ctrl
   import orwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SUM_GO    = 4'd1;
   localparam logic [3:0] S_SUM_WAIT  = 4'd2;
   localparam logic [3:0] S_MEAN_GO   = 4'd3;
   localparam logic [3:0] S_MEAN_WAIT = 4'd4;
   localparam logic [3:0] S_DEV_GO    = 4'd5;
   localparam logic [3:0] S_DEV_WAIT  = 4'd6;
   localparam logic [3:0] S_BAND      = 4'd7;
   localparam logic [3:0] S_KEEP_GO   = 4'd8;
   localparam logic [3:0] S_KEEP_WAIT = 4'd9;
   localparam logic [3:0] S_FILT_GO   = 4'd10;
   localparam logic [3:0] S_FILT_WAIT = 4'd11;
   localparam logic [3:0] S_DUTY_GO   = 4'd12;
   localparam logic [3:0] S_DUTY_WAIT = 4'd13;
   localparam logic [3:0] S_DONE      = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               state_in  = S_SUM_GO;
            end
         end
         S_SUM_GO: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SUM_WAIT;
         end
         S_SUM_WAIT: begin
            if (stat.scan_done) begin
               state_in = S_MEAN_GO;
            end
         end
         S_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MEAN;
            state_in      = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (stat.div_done) begin
               state_in = S_DEV_GO;
            end
         end
         S_DEV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_DEV;
            state_in      = S_DEV_WAIT;
         end
         S_DEV_WAIT: begin
            if (stat.div_done) begin
               state_in = S_BAND;
            end
         end
         S_BAND: begin
            cmd.band_load = 1'b1;
            state_in      = S_KEEP_GO;
         end
         S_KEEP_GO: begin
            cmd.scan_start = 1'b1;
            cmd.keep_pass  = 1'b1;
            state_in       = S_KEEP_WAIT;
         end
         S_KEEP_WAIT: begin
            if (stat.scan_done) begin
               state_in = S_FILT_GO;
            end
         end
         S_FILT_GO: begin
            // An empty band leaves the filtered mean and duty at zero.
            if (stat.kept_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_FILT;
               state_in      = S_FILT_WAIT;
            end
         end
         S_FILT_WAIT: begin
            if (stat.div_done) begin
               state_in = S_DUTY_GO;
            end
         end
         S_DUTY_GO: begin
            // A zero full scale leaves the duty at zero.
            if (stat.fs_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_DUTY;
               state_in      = S_DUTY_WAIT;
            end
         end
         S_DUTY_WAIT: begin
            if (stat.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: hdl/orwm_checker.sv
// Port-level checks on the outlier-rejecting window mean, bound to the top level.
module orwm_checker
   import orwm_pkg::*;
#(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
)
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_filtered_mean,
   input logic [KEPT_W-1:0] rsp_kept_count,
   input logic [DATA_W-1:0] rsp_duty_percent
);

   // Reset drops any pending response.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_mean) &&
      $stable(rsp_kept_count) && $stable(rsp_duty_percent))
      else $error("stalled response changed");

   // An accepted request keeps the block busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // The kept count never exceeds the window length.
   a_kept_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept_count <= KEPT_W'(WINDOW_LEN))
      else $error("kept count beyond window length");

   // An empty band gives a zero mean and zero duty.
   a_empty_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kept_count == '0) |->
      (rsp_filtered_mean == '0) && (rsp_duty_percent == '0))
      else $error("nonzero result with empty band");

endmodule

bind outlier_rejecting_window_mean orwm_checker #(
   .WINDOW_LEN (WINDOW_LEN)
) u_orwm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_filtered_mean (rsp_filtered_mean),
   .rsp_kept_count    (rsp_kept_count),
   .rsp_duty_percent  (rsp_duty_percent)
);

// File: verif/outlier_rejecting_window_mean_checker.sv
// Checker for the outlier-rejecting window mean: predicts each response and compares it.
module outlier_rejecting_window_mean_checker
   import orwm_pkg::*;
#(
   parameter logic [2:0] TOL_ADDR = 3'd0,
   parameter logic [2:0] FS_ADDR  = 3'd4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [DATA_W-1:0] req_sample_mv,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [DATA_W-1:0] rsp_filtered_mean,
   input  logic [KEPT_W-1:0] rsp_kept_count,
   input  logic [DATA_W-1:0] rsp_duty_percent,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_results
);

   localparam int WIN_LEN = WINDOW_LEN_DEFAULT;

   typedef struct packed {
      logic [DATA_W-1:0] filtered_mean;
      logic [KEPT_W-1:0] kept_count;
      logic [DATA_W-1:0] duty_percent;
   } window_result_type;

   // Shadow copy of the window, its write position and the two registers.
   logic [DATA_W-1:0] window_copy [WIN_LEN];
   int unsigned       next_slot;
   logic [TOL_W-1:0]  tolerance;
   logic [FS_W-1:0]   full_scale;
   window_result_type awaited_results [$];
   int                mismatches = 0;

   // Trimmed mean of the current window, kept count and duty percent.
   function automatic window_result_type trimmed_window_mean();
      longint            total;
      longint            mean;
      longint            dev;
      longint            lo;
      longint            hi;
      longint            kept_sum;
      longint            filt;
      longint            duty;
      longint            entry;
      int                kept;
      window_result_type res;
      total = 0;
      for (int i = 0; i < WIN_LEN; i++) total += longint'(window_copy[i]);
      mean = total / WIN_LEN;
      dev  = (mean * longint'(tolerance)) / PCT;
      // The lower edge is signed, so a tolerance above one hundred lets every entry pass it.
      lo = mean - dev;
      hi = mean + dev;
      kept_sum = 0;
      kept     = 0;
      for (int i = 0; i < WIN_LEN; i++) begin
         entry = longint'(window_copy[i]);
         if (entry >= lo && entry <= hi) begin
            kept_sum += entry;
            kept++;
         end
      end
      // An empty band gives a zero mean.
      filt = (kept != 0) ? kept_sum / kept : 0;
      // A zero full scale gives zero duty; a duty beyond sixteen bits saturates.
      duty = 0;
      if (full_scale != 0) begin
         duty = (filt * PCT) / longint'(full_scale);
         if (duty > 65535) duty = 65535;
      end
      res.filtered_mean = filt[DATA_W-1:0];
      res.kept_count    = kept[KEPT_W-1:0];
      res.duty_percent  = duty[DATA_W-1:0];
      return res;
   endfunction

   // Track register writes, predict each request and check each response.
   always @(posedge clock) begin
      window_result_type oldest;
      if (reset) begin
         for (int i = 0; i < WIN_LEN; i++) window_copy[i] = '0;
         next_slot  = 0;
         tolerance  = TOL_RESET;
         full_scale = FS_RESET;
         awaited_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               TOL_ADDR: tolerance  = csr_pwdata[TOL_W-1:0];
               FS_ADDR:  full_scale = csr_pwdata[FS_W-1:0];
               default: ;
            endcase
         end

         // The response is checked before this edge's request is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request waiting: mean %0d, kept %0d, duty %0d",
                      rsp_filtered_mean, rsp_kept_count, rsp_duty_percent);
               mismatches++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_filtered_mean !== oldest.filtered_mean) begin
                  $error("filtered_mean: expected %0d, actual %0d",
                         oldest.filtered_mean, rsp_filtered_mean);
                  mismatches++;
               end
               if (rsp_kept_count !== oldest.kept_count) begin
                  $error("kept_count: expected %0d, actual %0d",
                         oldest.kept_count, rsp_kept_count);
                  mismatches++;
               end
               if (rsp_duty_percent !== oldest.duty_percent) begin
                  $error("duty_percent: expected %0d, actual %0d",
                         oldest.duty_percent, rsp_duty_percent);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            window_copy[next_slot] = req_sample_mv;
            next_slot = (next_slot + 1 == WIN_LEN) ? 0 : next_slot + 1;
            awaited_results.push_back(trimmed_window_mean());
         end
      end
      fail_count      <= mismatches;
      pending_results <= awaited_results.size();
   end

endmodule

// File: verif/outlier_rejecting_window_mean_test.sv
// Testbench top for the outlier-rejecting window mean: clock, stimulus, registers and verdict.
module outlier_rejecting_window_mean_test
   import orwm_pkg::*;
();

   localparam logic [2:0] TOL_ADDR      = 3'd0;
   localparam logic [2:0] FS_ADDR       = 3'd4;
   localparam int         SETTLE_CYCLES = 2 * WINDOW_LEN_DEFAULT + 4 * (DIV_W + 2) + 20;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         SEGMENTS      = 6;
   localparam int         SEGMENT_ITEMS = 188;
   localparam int         DIRECTED_LEN  = 25;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_sample_mv = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_filtered_mean;
   logic [KEPT_W-1:0] rsp_kept_count;
   logic [DATA_W-1:0] rsp_duty_percent;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int fail_count;
   int pending_results;
   int send_idle_pct = 21;
   int recv_idle_pct = 45;
   int quiet_cycles  = 0;
   int cluster_base  = 1000;

   // Window extremes, an empty band, a filling window and a clean cluster.
   logic [DATA_W-1:0] directed_samples [DIRECTED_LEN] = '{
      16'hFFFF, 16'h0000, 16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd2000,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
      16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1234,
      16'hFFFF, 16'h8000, 16'h7FFF
   };

   always #4 clock = ~clock;

   outlier_rejecting_window_mean i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_mv     (req_sample_mv),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_mean (rsp_filtered_mean),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_duty_percent  (rsp_duty_percent),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   outlier_rejecting_window_mean_checker #(
      .TOL_ADDR (TOL_ADDR),
      .FS_ADDR  (FS_ADDR)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_mv     (req_sample_mv),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_mean (rsp_filtered_mean),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_duty_percent  (rsp_duty_percent),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // Random back-pressure on the response side.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: ends the run after too long without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[outlier_rejecting_window_mean] ERROR");
         $finish;
      end
   end

   // Offers one request after a random gap and returns at the edge that takes it.
   task automatic send_sample(input logic [DATA_W-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_mv <= sample;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops requests and waits until every response has come and the block is quiet.
   task automatic drain_block(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value,
                                 input logic [31:0] mask);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= (value & mask) | ($urandom & ~mask);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly clusters around a drifting level, with outliers, small values and extremes.
   function automatic logic [DATA_W-1:0] next_sample();
      int pick;
      int span;
      int value;
      if ($urandom_range(29) == 0) cluster_base = $urandom_range(65535);
      span = cluster_base / 16;
      pick = $urandom_range(19);
      if (pick < 2) begin
         value = $urandom_range(65535);
      end else if (pick < 4) begin
         value = $urandom_range(15);
      end else if (pick == 4) begin
         value = $urandom_range(1) ? 65535 : 0;
      end else if (pick < 8) begin
         value = cluster_base;
      end else begin
         value = cluster_base + $urandom_range(2 * span) - span;
         if (value < 0) value = 0;
         if (value > 65535) value = 65535;
      end
      return value[DATA_W-1:0];
   endfunction

   // Stimulus: directed requests at reset settings, then random segments per setting.
   initial begin
      int tol_value;
      int fs_value;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_samples[i]) send_sample(directed_samples[i]);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin tol_value = 0;   fs_value = 65535; end
            1: begin tol_value = 100; fs_value = 1;     end
            2: begin tol_value = 127; fs_value = 0;     end
            3: begin tol_value = $urandom_range(100); fs_value = $urandom_range(65535, 1); end
            4: begin tol_value = $urandom_range(30);  fs_value = $urandom_range(200, 1); end
            default: begin tol_value = TOL_RESET; fs_value = FS_RESET; end
         endcase
         if (seg < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 45;
         end else if (seg < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_block(4);
         write_register(TOL_ADDR, tol_value, 32'h0000_007F);
         write_register(FS_ADDR, fs_value, 32'h0000_FFFF);
         for (int n = 0; n < SEGMENT_ITEMS; n++) send_sample(next_sample());
      end

      drain_block(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("[outlier_rejecting_window_mean] OK");
      end else begin
         $display("[outlier_rejecting_window_mean] ERROR");
      end
      $finish;
   end

endmodule
